@@ hw/rtl/hmm_pkg.sv @@
`timescale 1ns / 1ps

package hmm_pkg;

	localparam int MAX_DIM = 8;
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * WORD_W;
	localparam int ACC_W = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int CFG_IDX_W = 3;
	localparam int DIM_W = 4;

	typedef enum logic [1:0] {
		CMD_WRITE_T = 2'd0,
		CMD_WRITE_A = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_READ_A  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIDE      = 3'd0,
		REG_TRIANGLE  = 3'd1,
		REG_TRANSPOSE = 3'd2,
		REG_ROWS      = 3'd3,
		REG_COLS      = 3'd4,
		REG_SCALE     = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic band;
	} mac_ctl_t;

endpackage

@@ hw/rtl/hmm_cell.sv @@
`timescale 1ns / 1ps

module hmm_cell (
	input  logic                           clk,
	input  logic                           op_shift,
	input  logic [hmm_pkg::WORD_W-1:0]     op_next,
	input  logic                           res_shift,
	input  logic [hmm_pkg::WORD_W-1:0]     res_next,
	output logic [hmm_pkg::WORD_W-1:0]     op_q,
	output logic [hmm_pkg::WORD_W-1:0]     res_q
);

	always_ff @(posedge clk) begin
		if (op_shift) begin
			op_q <= op_next;
		end
		if (res_shift) begin
			res_q <= res_next;
		end
	end

endmodule

@@ hw/rtl/hmm_mac.sv @@
`timescale 1ns / 1ps

module hmm_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hmm_pkg::mac_ctl_t                 ctl_s1,
	input  logic [hmm_pkg::WORD_W-1:0]        t_data,
	input  logic [hmm_pkg::WORD_W-1:0]        opa_s1,
	input  logic [hmm_pkg::WORD_W-1:0]        alpha,
	output logic                              res_valid,
	output logic [hmm_pkg::WORD_W-1:0]        res
);

	localparam int SW = hmm_pkg::ACC_W - hmm_pkg::FRAC_W;
	localparam int HI = hmm_pkg::WORD_W + hmm_pkg::FRAC_W - 1;
	localparam int P2_W = hmm_pkg::FRAC_W + 1 + hmm_pkg::WORD_W;
	localparam int R_W = hmm_pkg::PROD_W + 1;
	localparam logic signed [hmm_pkg::ACC_W-1:0] HALF_ACC =
		hmm_pkg::ACC_W'(1) <<< (hmm_pkg::FRAC_W - 1);
	localparam logic signed [P2_W-1:0] HALF_P2 = P2_W'(1) <<< (hmm_pkg::FRAC_W - 1);
	localparam logic signed [R_W-1:0] MAX_R = R_W'(33'sh0_7FFF_FFFF);
	localparam logic signed [R_W-1:0] MIN_R = -(R_W'(33'sh0_8000_0000));

	logic                              v_s2, first_s2, last_s2;
	logic signed [hmm_pkg::PROD_W-1:0] prod_s2;
	logic                              v_s3;
	logic signed [hmm_pkg::ACC_W-1:0]  acc_s3;
	logic                              v_s4, ovf_s4, pos_s4;
	logic signed [hmm_pkg::WORD_W-1:0] sh_s4;
	logic [hmm_pkg::FRAC_W-1:0]        sl_s4;
	logic                              v_s5, ovf_s5, pos_s5;
	logic signed [hmm_pkg::PROD_W-1:0] p1_s5;
	logic signed [P2_W-1:0]            p2_s5;

	logic signed [hmm_pkg::WORD_W-1:0] t_band;
	logic signed [hmm_pkg::ACC_W-1:0]  acc_rnd;
	logic signed [hmm_pkg::ACC_W-1:0]  acc_shr;
	logic signed [SW-1:0]              s_val;
	logic signed [P2_W-1:0]            p2_shr;
	logic signed [R_W-1:0]             r_sum;
	logic                              alpha_zero, alpha_pos;
	logic [hmm_pkg::WORD_W-1:0]        r_word;

	assign t_band = ctl_s1.band ? $signed(t_data) : '0;
	assign acc_rnd = acc_s3 + HALF_ACC;
	assign acc_shr = acc_rnd >>> hmm_pkg::FRAC_W;
	assign s_val = acc_shr[SW-1:0];
	assign alpha_zero = (alpha == '0);
	assign alpha_pos = !alpha[hmm_pkg::WORD_W-1] && !alpha_zero;
	assign p2_shr = (p2_s5 + HALF_P2) >>> hmm_pkg::FRAC_W;
	assign r_sum = R_W'(p1_s5) + R_W'(p2_shr);

	always_comb begin
		if (alpha_zero) begin
			r_word = '0;
		end else if (ovf_s5) begin
			r_word = (pos_s5 == alpha_pos) ? MAX_R[hmm_pkg::WORD_W-1:0]
				: MIN_R[hmm_pkg::WORD_W-1:0];
		end else if (r_sum > MAX_R) begin
			r_word = MAX_R[hmm_pkg::WORD_W-1:0];
		end else if (r_sum < MIN_R) begin
			r_word = MIN_R[hmm_pkg::WORD_W-1:0];
		end else begin
			r_word = r_sum[hmm_pkg::WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			v_s2 <= ctl_s1.valid;
			v_s3 <= v_s2 && last_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			res_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		first_s2 <= ctl_s1.first;
		last_s2 <= ctl_s1.last;
		prod_s2 <= t_band * $signed(opa_s1);
		if (v_s2) begin
			acc_s3 <= (first_s2 ? '0 : acc_s3) + hmm_pkg::ACC_W'(prod_s2);
		end
		// The exact sum is rounded once, then split so that each alpha
		// product stays within a 32-bit multiplier.
		ovf_s4 <= !((&s_val[SW-1:HI]) || !(|s_val[SW-1:HI]));
		pos_s4 <= !s_val[SW-1] && (|s_val);
		sh_s4 <= s_val[HI:hmm_pkg::FRAC_W];
		sl_s4 <= s_val[hmm_pkg::FRAC_W-1:0];
		ovf_s5 <= ovf_s4;
		pos_s5 <= pos_s4;
		p1_s5 <= sh_s4 * $signed(alpha);
		p2_s5 <= $signed({1'b0, sl_s4}) * $signed(alpha);
		res <= r_word;
	end

endmodule

@@ hw/rtl/hessenberg_matrix_multiply_top.sv @@
`timescale 1ns / 1ps

// Hessenberg matrix multiply on signed Q16.16 words.
// The input channel carries one command word per handshake: write an entry
// of T, write an entry of A, compute, or read an entry of A. Writes give no
// output word; compute and read each give exactly one output word.
// A write goes straight into its store. A read registers the entry of A
// and then moves it into the output register. A compute walks A line by
// line (columns for side 0, rows for side 1, line length L and N lines).
// Each line is loaded into a row of cells, each of its L results is issued
// from the cells through the multiply and rounding pipeline, and the line
// is written back from the cells; with the single T memory read port and
// the one multiplier, the results of a line are formed one at a time.
// The block takes one command word at a time. The output register holds a
// finished word while the receiver stalls; during that time the input is
// stalled for every command, and a finished compute waits until the word
// has been taken.
// Reset clears the control state and loads the register defaults; the T and
// A stores hold no defined contents until written.
module hessenberg_matrix_multiply_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [hmm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hmm_pkg::WORD_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic [2:0]                          row_index,
	input  logic [2:0]                          col_index,
	input  logic signed [31:0]                  entry_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  read_value,
	output logic [2:0]                          out_row,
	output logic [2:0]                          out_col,
	output logic                                compute_done
);

	localparam int N = hmm_pkg::MAX_DIM;
	localparam int IW = hmm_pkg::IDX_W;
	localparam int CW = hmm_pkg::CNT_W;
	localparam int WW = hmm_pkg::WORD_W;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_LOAD, S_LWAIT, S_MAC, S_WAITR, S_STORE, S_DONE
	} state_t;

	state_t state_q;

	logic                          side_q, tri_q, trans_q;
	logic [hmm_pkg::DIM_W-1:0]     rows_q, cols_q;
	logic [WW-1:0]                 alpha_q;

	logic [CW-1:0] line_q, o_q, k_q;
	logic          ld_v_q;
	logic          out_valid_q, out_done_q;
	logic [WW-1:0] out_value_q;
	logic [2:0]    out_row_q, out_col_q;

	hmm_pkg::mac_ctl_t ctl_s1;
	logic [WW-1:0]     opa_s1;

	logic [WW-1:0] t_mem [hmm_pkg::DEPTH];
	logic [WW-1:0] a_mem [hmm_pkg::DEPTH];
	logic [WW-1:0] t_rd_q, a_rd_q;

	logic [CW-1:0] m_dim, n_dim, len, lines, len_m1;
	logic          k_last, o_last, line_last;
	logic          accept, out_free;
	logic [IW-1:0] hr, hc, tr, tc, lx;
	logic          band;
	logic [hmm_pkg::ADDR_W-1:0] t_raddr, line_addr, a_raddr, a_waddr;
	logic          a_we, t_we, host_wa;
	logic [WW-1:0] a_wdata;
	logic          op_shift, res_shift;
	logic [WW-1:0] op_wrap, res_v_word;
	logic          res_v;
	logic [WW-1:0] op_q [N];
	logic [WW-1:0] res_q [N];
	logic [WW-1:0] op_next [N];
	logic [WW-1:0] res_next [N];

	assign m_dim = (rows_q > hmm_pkg::DIM_W'(N)) ? CW'(N) : CW'(rows_q);
	assign n_dim = (cols_q > hmm_pkg::DIM_W'(N)) ? CW'(N) : CW'(cols_q);
	assign len = side_q ? n_dim : m_dim;
	assign lines = side_q ? m_dim : n_dim;
	assign len_m1 = len - CW'(1);
	assign k_last = (k_q == len_m1);
	assign o_last = (o_q == len_m1);
	assign line_last = (line_q + CW'(1) == lines);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;

	// Element (o, k) of op(H) for side 0 and (k, o) for side 1.
	always_comb begin
		hr = side_q ? k_q[IW-1:0] : o_q[IW-1:0];
		hc = side_q ? o_q[IW-1:0] : k_q[IW-1:0];
		tr = trans_q ? hc : hr;
		tc = trans_q ? hr : hc;
		if (tri_q) begin
			band = ({1'b0, tc} <= {1'b0, tr} + (IW+1)'(1));
		end else begin
			band = ({1'b0, tr} <= {1'b0, tc} + (IW+1)'(1));
		end
		t_raddr = {tr, tc};
		lx = (state_q == S_STORE) ? o_q[IW-1:0] : k_q[IW-1:0];
		line_addr = side_q ? {line_q[IW-1:0], lx} : {lx, line_q[IW-1:0]};
	end

	assign host_wa = accept && (cmd == hmm_pkg::CMD_WRITE_A);
	assign t_we = accept && (cmd == hmm_pkg::CMD_WRITE_T);
	assign a_we = host_wa || (state_q == S_STORE);
	assign a_waddr = host_wa ? {row_index, col_index} : line_addr;
	assign a_wdata = host_wa ? entry_value : res_q[0];
	assign a_raddr = (state_q == S_IDLE) ? {row_index, col_index} : line_addr;

	always_ff @(posedge clk) begin
		if (t_we) begin
			t_mem[{row_index, col_index}] <= entry_value;
		end
		t_rd_q <= t_mem[t_raddr];
		if (a_we) begin
			a_mem[a_waddr] <= a_wdata;
		end
		a_rd_q <= a_mem[a_raddr];
	end

	// The operand row rotates toward cell 0 with the wrap at the line end;
	// during a load the arriving word enters at the wrap point.
	assign op_shift = ld_v_q || (state_q == S_MAC);
	assign op_wrap = ld_v_q ? a_rd_q : op_q[0];
	assign res_shift = res_v || (state_q == S_STORE);

	for (genvar g = 0; g < N; g++) begin : g_cells
		if (g == N - 1) begin : g_end
			assign op_next[g] = op_wrap;
			assign res_next[g] = res_v_word;
		end else begin : g_mid
			assign op_next[g] = (CW'(g) == len_m1) ? op_wrap : op_q[g+1];
			assign res_next[g] = (CW'(g) == len_m1) ? res_v_word : res_q[g+1];
		end
		hmm_cell u_cell (
			.clk      (clk),
			.op_shift (op_shift),
			.op_next  (op_next[g]),
			.res_shift(res_shift),
			.res_next (res_next[g]),
			.op_q     (op_q[g]),
			.res_q    (res_q[g])
		);
	end

	hmm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.t_data   (t_rd_q),
		.opa_s1   (opa_s1),
		.alpha    (alpha_q),
		.res_valid(res_v),
		.res      (res_v_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 1'b0;
			tri_q <= 1'b0;
			trans_q <= 1'b0;
			rows_q <= hmm_pkg::DIM_W'(8);
			cols_q <= hmm_pkg::DIM_W'(8);
			alpha_q <= WW'(65536);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				hmm_pkg::REG_SIDE:      side_q <= cfg_data[0];
				hmm_pkg::REG_TRIANGLE:  tri_q <= cfg_data[0];
				hmm_pkg::REG_TRANSPOSE: trans_q <= cfg_data[0];
				hmm_pkg::REG_ROWS:      rows_q <= cfg_data[hmm_pkg::DIM_W-1:0];
				hmm_pkg::REG_COLS:      cols_q <= cfg_data[hmm_pkg::DIM_W-1:0];
				hmm_pkg::REG_SCALE:     alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		opa_s1 <= op_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			line_q <= '0;
			o_q <= '0;
			k_q <= '0;
			ld_v_q <= 1'b0;
			ctl_s1 <= '0;
			out_valid_q <= 1'b0;
			out_done_q <= 1'b0;
			out_value_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else begin
			ld_v_q <= (state_q == S_LOAD);
			ctl_s1.valid <= (state_q == S_MAC);
			ctl_s1.first <= (k_q == '0);
			ctl_s1.last <= k_last;
			ctl_s1.band <= band;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					line_q <= '0;
					o_q <= '0;
					k_q <= '0;
					if (accept && cmd == hmm_pkg::CMD_COMPUTE) begin
						state_q <= (m_dim == '0 || n_dim == '0) ? S_DONE : S_LOAD;
					end else if (accept && cmd == hmm_pkg::CMD_READ_A) begin
						state_q <= S_RD;
						out_row_q <= row_index;
						out_col_q <= col_index;
					end
				end
				S_RD: begin
					out_valid_q <= 1'b1;
					out_done_q <= 1'b0;
					out_value_q <= a_rd_q;
					state_q <= S_IDLE;
				end
				S_LOAD: begin
					if (k_last) begin
						k_q <= '0;
						state_q <= S_LWAIT;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_LWAIT: begin
					o_q <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (k_last) begin
						k_q <= '0;
						state_q <= S_WAITR;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_WAITR: begin
					if (res_v) begin
						if (o_last) begin
							o_q <= '0;
							state_q <= S_STORE;
						end else begin
							o_q <= o_q + CW'(1);
							state_q <= S_MAC;
						end
					end
				end
				S_STORE: begin
					if (o_last) begin
						o_q <= '0;
						line_q <= line_q + CW'(1);
						state_q <= line_last ? S_DONE : S_LOAD;
					end else begin
						o_q <= o_q + CW'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_done_q <= 1'b1;
						out_value_q <= '0;
						out_row_q <= '0;
						out_col_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_value = out_value_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign compute_done = out_done_q;

	a_res_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res_v |-> state_q == S_WAITR)
		else $error("result left the pipeline outside its wait state");

	a_rd_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> !out_valid_q)
		else $error("read data would overwrite a pending output word");

	a_load_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ld_v_q |-> (state_q == S_LOAD || state_q == S_LWAIT))
		else $error("load data arrived outside the load phase");

	a_store_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STORE |-> o_q < len)
		else $error("write-back index beyond the line length");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && out_done_q))
		else $error("finished compute did not present its word");

endmodule

@@ test/tb_hessenberg_matrix_multiply_top.sv @@
`timescale 1ns / 1ps

module tb_hessenberg_matrix_multiply_top;

	typedef struct {
		logic signed [31:0] value;
		logic [2:0] row;
		logic [2:0] col;
		logic done;
	} answer_t;

	localparam longint SUM_LIMIT = longint'(1) <<< 47;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic cfg_write_en = 1'b0;
	logic [hmm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hmm_pkg::WORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [2:0] row_index = '0;
	logic [2:0] col_index = '0;
	logic signed [31:0] entry_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] read_value;
	logic [2:0] out_row;
	logic [2:0] out_col;
	logic compute_done;

	hessenberg_matrix_multiply_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.row_index(row_index),
		.col_index(col_index),
		.entry_value(entry_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.out_row(out_row),
		.out_col(out_col),
		.compute_done(compute_done)
	);

	always #5 clk = ~clk;

	// Shadow copy of the block's matrices and registers.
	logic signed [31:0] t_mem [0:hmm_pkg::DEPTH-1];
	logic signed [31:0] a_mem [0:hmm_pkg::DEPTH-1];
	logic side_reg = 1'b0;
	logic tri_reg = 1'b0;
	logic trans_reg = 1'b0;
	logic [3:0] rows_reg = 4'd8;
	logic [3:0] cols_reg = 4'd8;
	logic signed [31:0] alpha_reg = 32'sd65536;

	answer_t pending_answers[$];
	int mismatches = 0;
	int reads_seen = 0;
	int computes_seen = 0;
	int words_sent = 0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int hold_cycles = 0;
	int burst_left = 0;

	function automatic longint band_entry(int r, int c);
		int tr;
		int tc;
		bit in_band;
		tr = trans_reg ? c : r;
		tc = trans_reg ? r : c;
		in_band = tri_reg ? (tc <= tr + 1) : (tr <= tc + 1);
		if (!in_band)
			return 0;
		return longint'(t_mem[tr * hmm_pkg::MAX_DIM + tc]);
	endfunction

	// The sum is carried as an integer part and a low 16-bit part, exactly.
	function automatic logic signed [31:0] round_scale(longint hs, longint ls);
		longint s;
		longint sl;
		longint sh;
		longint r;
		longint alpha;
		alpha = longint'(alpha_reg);
		s = hs + ((ls + 32768) >>> 16);
		if (alpha == 0)
			return 32'sd0;
		if (s >= SUM_LIMIT || s < -SUM_LIMIT) begin
			r = ((s > 0) == (alpha > 0)) ? WORD_MAX : WORD_MIN;
		end else begin
			sl = s & 64'hFFFF;
			sh = s >>> 16;
			r = sh * alpha + ((sl * alpha + 32768) >>> 16);
		end
		if (r > WORD_MAX)
			r = WORD_MAX;
		if (r < WORD_MIN)
			r = WORD_MIN;
		return r[31:0];
	endfunction

	function automatic void multiply_by_band();
		int m;
		int n;
		longint hs;
		longint ls;
		longint p;
		logic signed [31:0] line [0:hmm_pkg::MAX_DIM-1];
		m = (rows_reg > hmm_pkg::MAX_DIM) ? hmm_pkg::MAX_DIM : rows_reg;
		n = (cols_reg > hmm_pkg::MAX_DIM) ? hmm_pkg::MAX_DIM : cols_reg;
		if (m == 0 || n == 0)
			return;
		if (!side_reg) begin
			for (int j = 0; j < n; j++) begin
				for (int i = 0; i < m; i++) begin
					hs = 0;
					ls = 0;
					for (int k = 0; k < m; k++) begin
						p = band_entry(i, k) *
							longint'(a_mem[k * hmm_pkg::MAX_DIM + j]);
						hs += p >>> 16;
						ls += p & 64'hFFFF;
					end
					line[i] = round_scale(hs, ls);
				end
				for (int i = 0; i < m; i++)
					a_mem[i * hmm_pkg::MAX_DIM + j] = line[i];
			end
		end else begin
			for (int i = 0; i < m; i++) begin
				for (int j = 0; j < n; j++) begin
					hs = 0;
					ls = 0;
					for (int k = 0; k < n; k++) begin
						p = longint'(a_mem[i * hmm_pkg::MAX_DIM + k]) *
							band_entry(k, j);
						hs += p >>> 16;
						ls += p & 64'hFFFF;
					end
					line[j] = round_scale(hs, ls);
				end
				for (int j = 0; j < n; j++)
					a_mem[i * hmm_pkg::MAX_DIM + j] = line[j];
			end
		end
	endfunction

	function automatic logic signed [31:0] pick_value();
		int sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return 32'sh7FFFFFFF;
		if (sel == 1)
			return 32'sh80000000;
		if (sel < 5)
			return $urandom();
		return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
	endfunction

	// Receiver stall: long hold-off when asked, random bursts while recv_idle is set.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (burst_left > 0) begin
			out_stall <= 1'b1;
			burst_left <= burst_left - 1;
		end else if (recv_idle && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			burst_left <= $urandom_range(0, 13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output word: value %h row %0d col %0d done %b",
						read_value, out_row, out_col, compute_done);
			end else begin
				want = pending_answers.pop_front();
				if (want.done)
					computes_seen++;
				else
					reads_seen++;
				if (read_value !== want.value || out_row !== want.row ||
						out_col !== want.col || compute_done !== want.done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%0d/%0d/%b got %h/%0d/%0d/%b",
							want.value, want.row, want.col, want.done,
							read_value, out_row, out_col, compute_done);
				end
			end
		end
	end

	task automatic send_word(hmm_pkg::cmd_t c, logic [2:0] r, logic [2:0] k,
			logic signed [31:0] v);
		int gap;
		answer_t ans;
		gap = (send_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		row_index <= r;
		col_index <= k;
		entry_value <= v;
		do @(posedge clk); while (in_stall);
		words_sent++;
		case (c)
			hmm_pkg::CMD_WRITE_T: t_mem[r * hmm_pkg::MAX_DIM + k] = v;
			hmm_pkg::CMD_WRITE_A: a_mem[r * hmm_pkg::MAX_DIM + k] = v;
			hmm_pkg::CMD_COMPUTE: begin
				multiply_by_band();
				ans = '{32'sd0, 3'd0, 3'd0, 1'b1};
				pending_answers.push_back(ans);
			end
			default: begin
				ans = '{a_mem[r * hmm_pkg::MAX_DIM + k], r, k, 1'b0};
				pending_answers.push_back(ans);
			end
		endcase
	endtask

	// Stops sending and waits until every answer is back and a write has landed.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(hmm_pkg::reg_index_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			hmm_pkg::REG_SIDE: side_reg = data[0];
			hmm_pkg::REG_TRIANGLE: tri_reg = data[0];
			hmm_pkg::REG_TRANSPOSE: trans_reg = data[0];
			hmm_pkg::REG_ROWS: rows_reg = data[3:0];
			hmm_pkg::REG_COLS: cols_reg = data[3:0];
			default: alpha_reg = data;
		endcase
	endtask

	task automatic send_random(int count);
		int sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 30)
				send_word(hmm_pkg::CMD_WRITE_T, 3'($urandom()), 3'($urandom()),
					pick_value());
			else if (sel < 60)
				send_word(hmm_pkg::CMD_WRITE_A, 3'($urandom()), 3'($urandom()),
					pick_value());
			else if (sel < 94)
				send_word(hmm_pkg::CMD_READ_A, 3'($urandom()), 3'($urandom()),
					32'($urandom()));
			else
				send_word(hmm_pkg::CMD_COMPUTE, 3'($urandom()), 3'($urandom()),
					32'($urandom()));
		end
	endtask

	// Every entry is written first, so no read ever sees an unwritten word.
	task automatic test_fill_matrices();
		for (int r = 0; r < hmm_pkg::MAX_DIM; r++)
			for (int k = 0; k < hmm_pkg::MAX_DIM; k++) begin
				send_word(hmm_pkg::CMD_WRITE_T, 3'(r), 3'(k), pick_value());
				send_word(hmm_pkg::CMD_WRITE_A, 3'(r), 3'(k), pick_value());
			end
	endtask

	task automatic test_directed();
		send_word(hmm_pkg::CMD_WRITE_A, 3'd0, 3'd0, 32'sh7FFFFFFF);
		send_word(hmm_pkg::CMD_WRITE_A, 3'd7, 3'd7, 32'sh80000000);
		send_word(hmm_pkg::CMD_WRITE_T, 3'd7, 3'd0, 32'sh00010000);
		send_word(hmm_pkg::CMD_READ_A, 3'd0, 3'd0, 32'sh0);
		send_word(hmm_pkg::CMD_READ_A, 3'd7, 3'd7, 32'sh0);
		send_word(hmm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'sh0);
		send_word(hmm_pkg::CMD_READ_A, 3'd0, 3'd0, 32'sh0);
		send_word(hmm_pkg::CMD_READ_A, 3'd7, 3'd7, 32'sh0);
		drain();
		// Zero size leaves A alone; zero alpha clears the used part only.
		write_reg(hmm_pkg::REG_ROWS, 32'd0);
		send_word(hmm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'sh0);
		send_word(hmm_pkg::CMD_READ_A, 3'd0, 3'd0, 32'sh0);
		drain();
		write_reg(hmm_pkg::REG_ROWS, 32'd3);
		write_reg(hmm_pkg::REG_COLS, 32'd15);
		write_reg(hmm_pkg::REG_SCALE, 32'd0);
		send_word(hmm_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'sh0);
		send_word(hmm_pkg::CMD_READ_A, 3'd2, 3'd7, 32'sh0);
		send_word(hmm_pkg::CMD_READ_A, 3'd3, 3'd0, 32'sh0);
		drain();
	endtask

	task automatic test_settings_sweep();
		logic [31:0] alpha;
		for (int s = 0; s < 12; s++) begin
			write_reg(hmm_pkg::REG_SIDE, 32'(s[0]));
			write_reg(hmm_pkg::REG_TRIANGLE, 32'(s[1]));
			write_reg(hmm_pkg::REG_TRANSPOSE, 32'(s[2]));
			write_reg(hmm_pkg::REG_ROWS, (s == 3) ? 32'd15 : $urandom_range(0, 9));
			write_reg(hmm_pkg::REG_COLS, (s == 5) ? 32'd8 : $urandom_range(1, 10));
			case ($urandom_range(0, 6))
				0: alpha = 32'h7FFFFFFF;
				1: alpha = 32'h80000000;
				2: alpha = 32'hFFFF0000;
				3: alpha = 32'h00010000;
				4: alpha = $urandom();
				default: alpha = $urandom_range(0, 32'h30000) - 32'h18000;
			endcase
			write_reg(hmm_pkg::REG_SCALE, alpha);
			send_random(80);
			drain();
		end
	endtask

	task automatic test_output_hold_off();
		@(posedge clk);
		hold_cycles = 400;
		send_random(30);
		drain();
	endtask

	task automatic test_pause_for_answers();
		send_random(20);
		drain();
		send_random(20);
		drain();
	endtask

	task automatic test_full_rate();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		write_reg(hmm_pkg::REG_ROWS, 32'd4);
		write_reg(hmm_pkg::REG_COLS, 32'd5);
		write_reg(hmm_pkg::REG_SCALE, 32'h00010000);
		send_random(150);
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_fill_matrices();
		test_directed();
		test_settings_sweep();
		test_output_hold_off();
		test_pause_for_answers();
		test_full_rate();
		$display("Sent %0d words over all side, band and transpose settings.", words_sent);
		$display("Checked %0d reads and %0d computes.", reads_seen, computes_seen);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule
